/* hdl/heightmap_normal_stencil_unit_macros.svh */
// Assertion macros shared by the stencil unit's RTL files.
// No dependencies; taken in by `include where assertions are written.
`ifndef HEIGHTMAP_NORMAL_STENCIL_UNIT_MACROS_SVH
`define HEIGHTMAP_NORMAL_STENCIL_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define HNS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("hns: invariant violated");

// antecedent implies consequent in the same cycle
`define HNS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hns: implication violated");

// antecedent implies consequent in the next cycle
`define HNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hns: sequence violated");

`endif

/* hdl/hns_pkg.sv */
// Types and constants of the height-map normal stencil unit.
// No dependencies; used through scoped names by every file but the macro header.
`default_nettype none

package hns_pkg;

	localparam int SUM_W  = 10; // r+g+b, at most 765
	localparam int LOC_W  = 10; // reported column and row
	localparam int NRM_W  = 16; // Q1.14 normal component
	localparam int REG_AW = 5;  // APB address bits
	localparam int FIFO_DEPTH = 4;
	localparam int DIV_STEPS  = 16;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH   = 3'd0,
		REG_GRID_HEIGHT  = 3'd1,
		REG_HEIGHT_SCALE = 3'd2,
		REG_STEP_X       = 3'd3,
		REG_STEP_Y       = 3'd4
	} reg_idx_t;

	// one stencil to evaluate: neighbour sums, edge weights and location
	typedef struct packed {
		logic [SUM_W-1:0] sl;
		logic [SUM_W-1:0] sr;
		logic [SUM_W-1:0] st;
		logic [SUM_W-1:0] sb;
		logic [1:0]       kx;
		logic [1:0]       ky;
		logic [LOC_W-1:0] col;
		logic [LOC_W-1:0] row;
		logic             last;
	} job_t;

	typedef struct packed {
		logic [15:0] height_scale;
		logic [15:0] step_x;
		logic [15:0] step_y;
	} coeff_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RD_LEFT,
		F_RD_CENTRE,
		F_RD_RIGHT,
		F_RD_LEFT2,
		F_WRITE,
		F_EMIT
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL1,
		B_MUL2,
		B_NORM,
		B_SQUARE,
		B_SUM,
		B_ROOT,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

`default_nettype wire

/* hdl/hns_stream_if.sv */
// Valid/ready stream interfaces: pixel input and normal output.
// Depends on hns_pkg for field widths.
`default_nettype none

interface hns_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

interface hns_normal_if;
	logic                             valid;
	logic                             ready;
	logic signed [hns_pkg::NRM_W-1:0] normal_x;
	logic signed [hns_pkg::NRM_W-1:0] normal_y;
	logic signed [hns_pkg::NRM_W-1:0] normal_z;
	logic [hns_pkg::LOC_W-1:0]        point_column;
	logic [hns_pkg::LOC_W-1:0]        point_row;
	logic                             frame_last;
	modport source(output valid, normal_x, normal_y, normal_z, point_column, point_row,
		frame_last, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, point_column, point_row,
		frame_last, output ready);
endinterface

`default_nettype wire

/* hdl/heightmap_normal_stencil_unit.sv */
// Flow: a pixel passes the row-buffer read and write states of the front end before its
// jobs are pushed; each job then passes multiply, range reduction, square, sum, the
// bit-serial root and the division in the back end on its way to the result port.
// Pacing: the back end takes a new job only once its last normal is loaded for output;
// the front end takes no new pixel until the last one's jobs are pushed (row 0 has none).
// Reset: arst_n clears counters, queue and state; registers return to their defaults.
`default_nettype none

module heightmap_normal_stencil_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	hns_pixel_if.sink                    pix,
	hns_normal_if.source                 nrm,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [hns_pkg::REG_AW-1:0]   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [10:0] grid_width_q, grid_height_q;
	logic [15:0] height_scale_q, step_x_q, step_y_q;
	hns_pkg::reg_idx_t reg_idx;
	logic wr_en;

	hns_pkg::job_t   push_data, pop_data;
	hns_pkg::coeff_t coeff;
	logic push, pop, full, empty;

	assign pready  = 1'b1;
	assign reg_idx = hns_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= 11'd256;
			grid_height_q  <= 11'd256;
			height_scale_q <= 16'd256;
			step_x_q       <= 16'd256;
			step_y_q       <= 16'd256;
		end else if (wr_en) begin
			case (reg_idx)
				hns_pkg::REG_GRID_WIDTH:   grid_width_q   <= pwdata[10:0];
				hns_pkg::REG_GRID_HEIGHT:  grid_height_q  <= pwdata[10:0];
				hns_pkg::REG_HEIGHT_SCALE: height_scale_q <= pwdata[15:0];
				hns_pkg::REG_STEP_X:       step_x_q       <= pwdata[15:0];
				hns_pkg::REG_STEP_Y:       step_y_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hns_pkg::REG_GRID_WIDTH:   prdata = {21'd0, grid_width_q};
			hns_pkg::REG_GRID_HEIGHT:  prdata = {21'd0, grid_height_q};
			hns_pkg::REG_HEIGHT_SCALE: prdata = {16'd0, height_scale_q};
			hns_pkg::REG_STEP_X:       prdata = {16'd0, step_x_q};
			hns_pkg::REG_STEP_Y:       prdata = {16'd0, step_y_q};
			default:                   prdata = 32'd0;
		endcase
	end

	assign coeff = '{height_scale: height_scale_q, step_x: step_x_q, step_y: step_y_q};

	hns_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.job_full    (full),
		.job_push    (push),
		.job_data    (push_data)
	);

	hns_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	hns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job_in    (pop_data),
		.coeff     (coeff),
		.job_pop   (pop),
		.nrm       (nrm)
	);

endmodule

`default_nettype wire

/* hdl/hns_front.sv */
// Front end: pixel intake, raster counters, row buffer and stencil job issue.
// Depends on hns_pkg and hns_pixel_if.
`default_nettype none

module hns_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	hns_pixel_if.sink           pix,
	input  wire  [10:0]         grid_width,
	input  wire  [10:0]         grid_height,
	input  wire                 job_full,
	output logic                job_push,
	output hns_pkg::job_t       job_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SW = hns_pkg::SUM_W;
	localparam int EW = 2 * SW;

	hns_pkg::front_state_t state_q, state_d;

	logic [AW-1:0] col_cnt_q, col_q;
	logic [HW-1:0] row_cnt_q, row_q;
	logic          lastc_q, lastr_q;
	logic [SW-1:0] cur_q;
	logic [EW-1:0] left_q, cent_q;
	logic [SW-1:0] rmid_q, l2mid_q;
	logic [2:0]    pend_q, pend_d;

	// row buffer entry: upper (two rows back) above, middle (previous row) below
	logic [EW-1:0] mem [MAX_WIDTH];
	logic [AW-1:0] raddr;
	logic [EW-1:0] rdata_q;
	logic          we;

	logic [12:0]   w_ext, h_ext, w_cl, h_cl;
	logic [AW-1:0] wm1, colc;
	logic [HW-1:0] hm1, rowc;
	logic          lastc, lastr, accept;

	hns_pkg::job_t job0, job1, job2;
	logic [SW-1:0] c0, c1;

	always_comb begin
		w_ext = {2'b00, grid_width};
		h_ext = {2'b00, grid_height};
		if (w_ext < 13'd2) w_cl = 13'd2;
		else if (w_ext > 13'(MAX_WIDTH)) w_cl = 13'(MAX_WIDTH);
		else w_cl = w_ext;
		if (h_ext < 13'd2) h_cl = 13'd2;
		else if (h_ext > 13'(MAX_HEIGHT)) h_cl = 13'(MAX_HEIGHT);
		else h_cl = h_ext;
		wm1 = AW'(w_cl - 13'd1);
		hm1 = HW'(h_cl - 13'd1);
		colc = (col_cnt_q >= wm1) ? wm1 : col_cnt_q;
		rowc = (row_cnt_q >= hm1) ? hm1 : row_cnt_q;
		lastc = (colc == wm1);
		lastr = (rowc == hm1);
	end

	assign accept = pix.valid && pix.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hns_pkg::F_IDLE:      if (pix.valid) state_d = hns_pkg::F_RD_LEFT;
			hns_pkg::F_RD_LEFT:   state_d = hns_pkg::F_RD_CENTRE;
			hns_pkg::F_RD_CENTRE: state_d = hns_pkg::F_RD_RIGHT;
			hns_pkg::F_RD_RIGHT:  state_d = hns_pkg::F_RD_LEFT2;
			hns_pkg::F_RD_LEFT2:  state_d = hns_pkg::F_WRITE;
			hns_pkg::F_WRITE:     state_d = hns_pkg::F_EMIT;
			hns_pkg::F_EMIT:      if (pend_d == 3'b000) state_d = hns_pkg::F_IDLE;
			default:              state_d = hns_pkg::F_IDLE;
		endcase
	end

	// stencil neighbourhoods of the up to three points due after this pixel
	always_comb begin
		c0 = cent_q[SW-1:0];
		job0.sl   = (col_q != '0) ? left_q[EW-1:SW] : c0;
		job0.sr   = lastc_q ? c0 : rmid_q;
		job0.st   = (row_q == HW'(1)) ? c0 : cent_q[EW-1:SW];
		job0.sb   = cur_q;
		job0.kx   = {1'b0, col_q != '0} + {1'b0, !lastc_q};
		job0.ky   = (row_q == HW'(1)) ? 2'd1 : 2'd2;
		job0.col  = hns_pkg::LOC_W'(col_q);
		job0.row  = hns_pkg::LOC_W'(row_q - HW'(1));
		job0.last = 1'b0;

		c1 = left_q[SW-1:0];
		job1.sl   = (col_q >= AW'(2)) ? l2mid_q : c1;
		job1.sr   = cur_q;
		job1.st   = left_q[EW-1:SW];
		job1.sb   = c1;
		job1.kx   = (col_q >= AW'(2)) ? 2'd2 : 2'd1;
		job1.ky   = 2'd1;
		job1.col  = hns_pkg::LOC_W'(col_q - AW'(1));
		job1.row  = hns_pkg::LOC_W'(row_q);
		job1.last = 1'b0;

		job2.sl   = left_q[SW-1:0];
		job2.sr   = cur_q;
		job2.st   = cent_q[SW-1:0];
		job2.sb   = cur_q;
		job2.kx   = 2'd1;
		job2.ky   = 2'd1;
		job2.col  = hns_pkg::LOC_W'(col_q);
		job2.row  = hns_pkg::LOC_W'(row_q);
		job2.last = 1'b1;
	end

	// outputs and buffer addressing
	always_comb begin
		pix.ready = 1'b0;
		raddr     = col_q;
		we        = 1'b0;
		job_push  = 1'b0;
		job_data  = job0;
		pend_d    = pend_q;
		case (state_q)
			hns_pkg::F_IDLE:      pix.ready = 1'b1;
			hns_pkg::F_RD_LEFT:   raddr = col_q - AW'(1);
			hns_pkg::F_RD_CENTRE: raddr = col_q;
			hns_pkg::F_RD_RIGHT:  raddr = col_q + AW'(1);
			hns_pkg::F_RD_LEFT2:  raddr = col_q - AW'(2);
			hns_pkg::F_WRITE:     we = 1'b1;
			hns_pkg::F_EMIT: begin
				if (!job_full && pend_q != 3'b000) begin
					job_push = 1'b1;
					if (pend_q[0]) begin
						job_data = job0;
						pend_d = {pend_q[2:1], 1'b0};
					end else if (pend_q[1]) begin
						job_data = job1;
						pend_d = {pend_q[2], 2'b00};
					end else begin
						job_data = job2;
						pend_d = 3'b000;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hns_pkg::F_IDLE;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			pend_q    <= 3'b000;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (lastc) begin
					col_cnt_q <= '0;
					row_cnt_q <= lastr ? '0 : rowc + HW'(1);
				end else begin
					col_cnt_q <= colc + AW'(1);
					row_cnt_q <= rowc;
				end
			end
			if (state_q == hns_pkg::F_WRITE)
				pend_q <= {lastr_q && lastc_q, lastr_q && (col_q != '0), row_q != '0};
			else
				pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q   <= SW'({2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue});
			col_q   <= colc;
			row_q   <= rowc;
			lastc_q <= lastc;
			lastr_q <= lastr;
		end
		case (state_q)
			hns_pkg::F_RD_CENTRE: left_q <= rdata_q;
			hns_pkg::F_RD_RIGHT:  cent_q <= rdata_q;
			hns_pkg::F_RD_LEFT2:  rmid_q <= rdata_q[SW-1:0];
			hns_pkg::F_WRITE:     l2mid_q <= rdata_q[SW-1:0];
			default: ;
		endcase
	end

	// row buffer: one write, one registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[col_q] <= {cent_q[SW-1:0], cur_q};
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/hns_job_fifo.sv */
// Short job queue between the stencil front end and the normal back end.
// Depends on hns_pkg.
`default_nettype none
`include "heightmap_normal_stencil_unit_macros.svh"

module hns_job_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  hns_pkg::job_t  push_data,
	input  wire            pop,
	output hns_pkg::job_t  pop_data,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = hns_pkg::FIFO_DEPTH;
	localparam int PW = $clog2(DEPTH);

	hns_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full     = (count_q == (PW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + (PW+1)'(1);
			else if (pop && !push) count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	`HNS_ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && full))
	`HNS_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, !empty)

endmodule

`default_nettype wire

/* hdl/hns_back.sv */
// Back end: cross product, range reduction, bit-serial root, Q1.14 division.
// Depends on hns_pkg and hns_normal_if; output register feeds the result port.
`default_nettype none
`include "heightmap_normal_stencil_unit_macros.svh"

module hns_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              job_valid,
	input  hns_pkg::job_t    job_in,
	input  hns_pkg::coeff_t  coeff,
	output logic             job_pop,
	hns_normal_if.source     nrm
);

	localparam int NW = hns_pkg::NRM_W;

	hns_pkg::back_state_t state_q, state_d;

	hns_pkg::job_t job_q;
	logic [18:0] a_q, b_q;
	logic [25:0] p0_q, p1_q;
	logic        negx_q, negy_q;
	logic [44:0] mag0_q, mag1_q, mag2_q;
	logic [59:0] sq0_q, sq1_q, sq2_q;
	logic [62:0] q_q, res_q, bit_q;
	logic [47:0] num0_q, num1_q, num2_q, dsh_q;
	logic [15:0] quo0_q, quo1_q, quo2_q;
	logic [3:0]  div_cnt_q;

	logic        out_valid_q;
	logic [NW-1:0] nx_q, ny_q, nz_q;
	logic [hns_pkg::LOC_W-1:0] col_out_q, row_out_q;
	logic        last_out_q;

	logic [16:0] ax, by;
	logic [18:0] a_c, b_c;
	logic [9:0]  dx, dy;
	logic        big;
	logic [62:0] trial;
	logic [31:0] root;
	logic        load_out;

	function automatic logic [15:0] to_field(input logic [15:0] v, input logic neg);
		if (v == 16'd0) return 16'd0;
		return neg ? 16'd0 - v : v;
	endfunction

	// 3*k*step with k in {1,2}, plus the sum differences, range check and root trial
	always_comb begin
		ax  = (job_in.kx == 2'd2) ? {coeff.step_x, 1'b0} : {1'b0, coeff.step_x};
		by  = (job_in.ky == 2'd2) ? {coeff.step_y, 1'b0} : {1'b0, coeff.step_y};
		a_c = {2'b00, ax} + {1'b0, ax, 1'b0};
		b_c = {2'b00, by} + {1'b0, by, 1'b0};
		dx  = (job_q.sr >= job_q.sl) ? job_q.sr - job_q.sl : job_q.sl - job_q.sr;
		dy  = (job_q.st >= job_q.sb) ? job_q.st - job_q.sb : job_q.sb - job_q.st;
		big = (|mag0_q[44:30]) || (|mag1_q[44:30]) || (|mag2_q[44:30]);
		trial = res_q + bit_q;
		root  = res_q[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hns_pkg::B_IDLE:   if (job_valid) state_d = hns_pkg::B_MUL1;
			hns_pkg::B_MUL1:   state_d = hns_pkg::B_MUL2;
			hns_pkg::B_MUL2:   state_d = hns_pkg::B_NORM;
			hns_pkg::B_NORM:   if (!big) state_d = hns_pkg::B_SQUARE;
			hns_pkg::B_SQUARE: state_d = hns_pkg::B_SUM;
			hns_pkg::B_SUM:    state_d = hns_pkg::B_ROOT;
			hns_pkg::B_ROOT:   if (bit_q == '0) state_d = hns_pkg::B_DIV;
			hns_pkg::B_DIV:    if (div_cnt_q == '0) state_d = hns_pkg::B_OUT;
			hns_pkg::B_OUT:    if (load_out) state_d = hns_pkg::B_IDLE;
			default:           state_d = hns_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop  = (state_q == hns_pkg::B_IDLE) && job_valid;
		load_out = (state_q == hns_pkg::B_OUT) && (!out_valid_q || nrm.ready);
	end

	assign nrm.valid        = out_valid_q;
	assign nrm.normal_x     = nx_q;
	assign nrm.normal_y     = ny_q;
	assign nrm.normal_z     = nz_q;
	assign nrm.point_column = col_out_q;
	assign nrm.point_row    = row_out_q;
	assign nrm.frame_last   = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hns_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (nrm.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hns_pkg::B_IDLE: begin
				job_q <= job_in;
				a_q   <= a_c;
				b_q   <= b_c;
			end
			hns_pkg::B_MUL1: begin
				p0_q   <= {16'd0, dx} * {10'd0, coeff.height_scale};
				p1_q   <= {16'd0, dy} * {10'd0, coeff.height_scale};
				negx_q <= (job_q.sr < job_q.sl);
				negy_q <= (job_q.st > job_q.sb);
			end
			hns_pkg::B_MUL2: begin
				mag0_q <= {19'd0, p0_q} * {26'd0, b_q};
				mag1_q <= {19'd0, p1_q} * {26'd0, a_q};
				mag2_q <= {26'd0, a_q} * {26'd0, b_q};
			end
			hns_pkg::B_NORM: begin
				// one bit per cycle until the largest fits in 30 bits
				if (big) begin
					mag0_q <= mag0_q >> 1;
					mag1_q <= mag1_q >> 1;
					mag2_q <= mag2_q >> 1;
				end
			end
			hns_pkg::B_SQUARE: begin
				sq0_q <= {30'd0, mag0_q[29:0]} * {30'd0, mag0_q[29:0]};
				sq1_q <= {30'd0, mag1_q[29:0]} * {30'd0, mag1_q[29:0]};
				sq2_q <= {30'd0, mag2_q[29:0]} * {30'd0, mag2_q[29:0]};
			end
			hns_pkg::B_SUM: begin
				q_q   <= 63'(sq0_q) + 63'(sq1_q) + 63'(sq2_q);
				res_q <= '0;
				bit_q <= 63'(1) << 62;
			end
			hns_pkg::B_ROOT: begin
				if (bit_q != '0) begin
					if (q_q >= trial) begin
						q_q   <= q_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					num0_q    <= (48'(mag0_q[29:0]) << 15) + 48'(root);
					num1_q    <= (48'(mag1_q[29:0]) << 15) + 48'(root);
					num2_q    <= (48'(mag2_q[29:0]) << 15) + 48'(root);
					dsh_q     <= 48'(root) << (hns_pkg::DIV_STEPS);
					div_cnt_q <= 4'(hns_pkg::DIV_STEPS - 1);
				end
			end
			hns_pkg::B_DIV: begin
				// restoring division by 2r, three lanes together
				if (num0_q >= dsh_q) begin
					num0_q <= num0_q - dsh_q;
					quo0_q <= {quo0_q[14:0], 1'b1};
				end else begin
					quo0_q <= {quo0_q[14:0], 1'b0};
				end
				if (num1_q >= dsh_q) begin
					num1_q <= num1_q - dsh_q;
					quo1_q <= {quo1_q[14:0], 1'b1};
				end else begin
					quo1_q <= {quo1_q[14:0], 1'b0};
				end
				if (num2_q >= dsh_q) begin
					num2_q <= num2_q - dsh_q;
					quo2_q <= {quo2_q[14:0], 1'b1};
				end else begin
					quo2_q <= {quo2_q[14:0], 1'b0};
				end
				dsh_q     <= dsh_q >> 1;
				div_cnt_q <= div_cnt_q - 4'd1;
			end
			default: ;
		endcase
		if (load_out) begin
			if (res_q == '0) begin
				nx_q <= '0;
				ny_q <= '0;
				nz_q <= '0;
			end else begin
				nx_q <= to_field(quo0_q, negx_q);
				ny_q <= to_field(quo1_q, negy_q);
				nz_q <= to_field(quo2_q, 1'b1);
			end
			col_out_q  <= job_q.col;
			row_out_q  <= job_q.row;
			last_out_q <= job_q.last;
		end
	end

	`HNS_ASSERT_IMPLIES(a_nx_range, clk, arst_n, out_valid_q, ($signed(nx_q) >= -16384) && ($signed(nx_q) <= 16384))
	`HNS_ASSERT_IMPLIES(a_nz_nonpos, clk, arst_n, out_valid_q, nz_q[NW-1] || (nz_q == '0))
	`HNS_ASSERT_NEXT(a_sum_to_root, clk, arst_n, state_q == hns_pkg::B_SUM, state_q == hns_pkg::B_ROOT)

endmodule

`default_nettype wire

/* verif/heightmap_normal_stencil_unit_tb.sv */
// Self-checking testbench for the height-map normal stencil unit.
// Depends on hns_pkg, the stream interfaces and the unit itself.
`timescale 1ns / 1ps

module heightmap_normal_stencil_unit_tb;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [9:0]  col;
		logic [9:0]  row;
		logic        last;
	} normal_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [hns_pkg::REG_AW-1:0] paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	hns_pixel_if  pix();
	hns_normal_if nrm();

	heightmap_normal_stencil_unit dut (
		.clk(clk), .arst_n(arst_n), .pix(pix), .nrm(nrm),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the block's registers and row buffers
	logic [10:0] grid_w, grid_h;
	logic [15:0] h_scale, step_x, step_y;
	int unsigned upper_sums[1024];
	int unsigned middle_sums[1024];
	int unsigned col_cnt, row_cnt;

	pixel_t  pixel_q[$];
	normal_t expected_normals[$];
	int      fail_count;
	int      normals_checked;
	int      pixels_sent;
	int      settings_used;
	bit      idle_on;
	int      src_gap, sink_gap;
	int      hold_req_n, hold_seen_n, hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#36ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint unsigned isqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic normal_t unit_normal(input int unsigned c, r, w, h,
			sl, sr, st, sb, input bit last);
		longint unsigned kx, ky, a, b, dx, dy, m, q, rt, v;
		longint unsigned mag[3];
		bit neg[3];
		logic [15:0] comp[3];
		int s;
		normal_t n;
		kx = (c > 0 ? 1 : 0) + (c < w - 1 ? 1 : 0);
		ky = (r > 0 ? 1 : 0) + (r < h - 1 ? 1 : 0);
		a = 3 * kx * step_x;
		b = 3 * ky * step_y;
		dx = (sr >= sl) ? sr - sl : sl - sr;
		dy = (st >= sb) ? st - sb : sb - st;
		mag[0] = dx * h_scale * b;  neg[0] = sr < sl;
		mag[1] = a * dy * h_scale;  neg[1] = st > sb;
		mag[2] = a * b;             neg[2] = 1'b1;
		m = mag[0];
		if (mag[1] > m) m = mag[1];
		if (mag[2] > m) m = mag[2];
		s = 0;
		while ((m >> s) >= (64'd1 << 30))
			s++;
		q = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] >>= s;
			q += mag[i] * mag[i];
		end
		rt = isqrt(q);
		for (int i = 0; i < 3; i++) begin
			v = (rt != 0) ? (mag[i] * 32768 + rt) / (2 * rt) : 0;
			comp[i] = (v != 0 && neg[i]) ? 16'(17'h10000 - v) : v[15:0];
		end
		n.nx = comp[0];
		n.ny = comp[1];
		n.nz = comp[2];
		n.col = c[9:0];
		n.row = r[9:0];
		n.last = last;
		return n;
	endfunction

	// advance the shadow stencil by one pixel and queue the normals it completes
	function automatic void predict_normals(input logic [7:0] rd, gn, bl);
		int unsigned w, h, c, r, cur, cc, lv, rv, tv;
		bit lastc, lastr;
		w = grid_w;
		h = grid_h;
		if (w < 2) w = 2;
		if (w > 1024) w = 1024;
		if (h < 2) h = 2;
		if (h > 1024) h = 1024;
		c = (col_cnt >= w) ? w - 1 : col_cnt;
		r = (row_cnt >= h) ? h - 1 : row_cnt;
		lastc = (c == w - 1);
		lastr = (r == h - 1);
		cur = rd + gn + bl;
		if (r >= 1) begin
			cc = middle_sums[c];
			lv = (c > 0) ? upper_sums[c - 1] : cc;
			rv = lastc ? cc : middle_sums[c + 1];
			tv = (r == 1) ? cc : upper_sums[c];
			expected_normals.push_back(unit_normal(c, r - 1, w, h, lv, rv, tv, cur, 1'b0));
		end
		upper_sums[c] = middle_sums[c];
		middle_sums[c] = cur;
		if (lastr) begin
			if (c >= 1) begin
				cc = middle_sums[c - 1];
				lv = (c >= 2) ? middle_sums[c - 2] : cc;
				expected_normals.push_back(unit_normal(c - 1, r, w, h, lv, cur,
					upper_sums[c - 1], cc, 1'b0));
			end
			if (lastc)
				expected_normals.push_back(unit_normal(c, r, w, h, middle_sums[c - 1], cur,
					upper_sums[c], cur, 1'b1));
		end
		if (lastc) begin
			col_cnt = 0;
			row_cnt = lastr ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (pix.valid && pix.ready) begin
				predict_normals(pix.red, pix.green, pix.blue);
				pixels_sent++;
			end
			if (!pix.valid || pix.ready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					pix.valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					pixel_t p;
					p = pixel_q.pop_front();
					pix.valid <= 1'b1;
					pix.red <= p.red;
					pix.green <= p.green;
					pix.blue <= p.blue;
					if (idle_on && $urandom_range(0, 11) == 0)
						src_gap <= $urandom_range(1, 19);
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen_n <= 0;
			hold_left <= 0;
		end else if (hold_seen_n != hold_req_n) begin
			hold_seen_n <= hold_req_n;
			hold_left <= 3000;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// normal monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm.ready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (nrm.valid && nrm.ready) begin
				if (expected_normals.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected normal at (%0d,%0d)", $realtime,
							nrm.point_column, nrm.point_row);
				end else begin
					normal_t e;
					e = expected_normals.pop_front();
					normals_checked++;
					if (nrm.normal_x !== e.nx || nrm.normal_y !== e.ny ||
							nrm.normal_z !== e.nz || nrm.point_column !== e.col ||
							nrm.point_row !== e.row || nrm.frame_last !== e.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: mismatch exp n=(%0d,%0d,%0d) at (%0d,%0d) ",
								"last %0b, got n=(%0d,%0d,%0d) at (%0d,%0d) last %0b"},
								$realtime, $signed(e.nx), $signed(e.ny), $signed(e.nz),
								e.col, e.row, e.last, nrm.normal_x, nrm.normal_y,
								nrm.normal_z, nrm.point_column, nrm.point_row,
								nrm.frame_last);
					end
				end
			end
			if (hold_left > 0) begin
				nrm.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				nrm.ready <= 1'b0;
			end else begin
				nrm.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 11) == 0)
					sink_gap <= $urandom_range(1, 19);
			end
		end
	end

	task automatic write_reg(input hns_pkg::reg_idx_t idx, input int unsigned val);
		logic [31:0] mask;
		mask = (idx == hns_pkg::REG_GRID_WIDTH || idx == hns_pkg::REG_GRID_HEIGHT) ?
			32'h7FF : 32'hFFFF;
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= hns_pkg::REG_AW'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		case (idx)
			hns_pkg::REG_GRID_WIDTH:   grid_w = val[10:0];
			hns_pkg::REG_GRID_HEIGHT:  grid_h = val[10:0];
			hns_pkg::REG_HEIGHT_SCALE: h_scale = val[15:0];
			hns_pkg::REG_STEP_X:       step_x = val[15:0];
			hns_pkg::REG_STEP_Y:       step_y = val[15:0];
			default: ;
		endcase
		// read back
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if ((prdata & mask) !== (val & mask)) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: register %0d read %0h, exp %0h", $realtime, idx,
					prdata & mask, val & mask);
		end
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic set_geometry(input int unsigned w, h, hs, sx, sy);
		write_reg(hns_pkg::REG_GRID_WIDTH, w);
		write_reg(hns_pkg::REG_GRID_HEIGHT, h);
		write_reg(hns_pkg::REG_HEIGHT_SCALE, hs);
		write_reg(hns_pkg::REG_STEP_X, sx);
		write_reg(hns_pkg::REG_STEP_Y, sy);
		settings_used++;
	endtask

	task automatic push_pixel(input int unsigned r, g, b);
		pixel_t p;
		p.red = r[7:0];
		p.green = g[7:0];
		p.blue = b[7:0];
		pixel_q.push_back(p);
	endtask

	task automatic push_random_pixels(input int unsigned n);
		repeat (n)
			push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// every pixel taken and every normal back; row-0 pixels may still be in flight
	task automatic wait_drained();
		@(negedge clk);
		while (pixel_q.size() != 0 || pix.valid || expected_normals.size() != 0)
			@(negedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic int unsigned pick_coeff();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(1, 16);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	initial begin
		int unsigned w, h, random_items;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		pix.valid = 1'b0; pix.red = '0; pix.green = '0; pix.blue = '0;
		nrm.ready = 1'b0;
		grid_w = 256; grid_h = 256; h_scale = 256; step_x = 256; step_y = 256;
		col_cnt = 0; row_cnt = 0;
		fail_count = 0; normals_checked = 0; pixels_sent = 0; settings_used = 0;
		hold_req_n = 0;
		idle_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 4x3 frame of channel extremes
		set_geometry(4, 3, 256, 256, 256);
		push_pixel(0, 0, 0);       push_pixel(255, 255, 255);
		push_pixel(255, 0, 0);     push_pixel(0, 255, 0);
		push_pixel(0, 0, 255);     push_pixel(255, 255, 255);
		push_pixel(0, 0, 0);       push_pixel(255, 255, 255);
		push_pixel(255, 255, 255); push_pixel(0, 0, 0);
		push_pixel(170, 85, 1);    push_pixel(0, 0, 0);
		wait_drained();
		// zero spacing gives a degenerate normal; width and height clamp up to 2
		set_geometry(1, 0, 16'hFFFF, 0, 0);
		push_pixel(255, 255, 255); push_pixel(0, 0, 0);
		push_pixel(0, 0, 0);       push_pixel(255, 255, 255);
		wait_drained();
		// width shrinks mid-frame: counter beyond the new last column
		set_geometry(6, 4, 300, 16'hFFFF, 1);
		push_random_pixels(16);
		wait_drained();
		write_reg(hns_pkg::REG_GRID_WIDTH, 3);
		push_random_pixels(4);
		wait_drained();

		// random frames; block fills while the receiver holds off once
		random_items = 0;
		while (random_items < 220) begin
			w = $urandom_range(2, 9);
			h = $urandom_range(2, 5);
			set_geometry(w, h, pick_coeff(), pick_coeff(), pick_coeff());
			if (settings_used == 6)
				hold_req_n++;
			if (random_items > 150)
				idle_on = 1'b0;
			push_random_pixels(w * h);
			random_items += w * h;
			if (settings_used == 8) begin
				// wait until every pixel is sent and every normal is back
				@(negedge clk);
				while (pixel_q.size() != 0 || pix.valid || expected_normals.size() != 0)
					@(negedge clk);
			end
			wait_drained();
		end

		// height register above the maximum: clamped, so the frame does not end early
		set_geometry(2, 2047, 256, $urandom_range(0, 16'hFFFF), 16'hFFFF);
		push_random_pixels(40);
		wait_drained();

		$display("Checked %0d normals from %0d pixels over %0d register settings,",
			normals_checked, pixels_sent, settings_used);
		$display("incl. clamped sizes, zero spacing, a mid-frame resize and output back-pressure.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/hns_pkg.sv
hdl/hns_stream_if.sv
hdl/hns_front.sv
hdl/hns_job_fifo.sv
hdl/hns_back.sv
hdl/heightmap_normal_stencil_unit.sv
verif/heightmap_normal_stencil_unit_tb.sv
